### rtl/ihex_pkg.sv
// Shared constants, types and helpers of the Intel HEX record encoder.
`timescale 1ns / 1ps
package ihex_pkg;

  // Record geometry
  localparam int RECORD_BYTES = 16;
  localparam int IDX_W        = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int FILL_W       = $clog2(RECORD_BYTES + 1);
  localparam int POS_W        = $clog2(RECORD_BYTES + 5);
  localparam int QUEUE_DEPTH  = 2;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_SEGMENT_BASE  = 2'd0;
  localparam logic [1:0] REG_START_ENABLE  = 2'd1;
  localparam logic [1:0] REG_START_SEGMENT = 2'd2;
  localparam logic [1:0] REG_START_OFFSET  = 2'd3;

  // Input operations
  localparam logic [1:0] OP_DATA      = 2'd0;
  localparam logic [1:0] OP_END_SEG   = 2'd1;
  localparam logic [1:0] OP_END_IMAGE = 2'd2;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  // Record types and fixed lengths
  localparam logic [7:0] REC_DATA      = 8'h00;
  localparam logic [7:0] REC_EOF       = 8'h01;
  localparam logic [7:0] REC_EXT_SEG   = 8'h02;
  localparam logic [7:0] REC_START_SEG = 8'h03;
  localparam logic [7:0] EXT_SEG_LEN   = 8'd2;
  localparam logic [7:0] START_SEG_LEN = 8'd4;
  localparam logic [7:0] EOF_LEN       = 8'd0;

  // Characters
  localparam logic [6:0] CH_COLON   = 7'h3A;
  localparam logic [6:0] CH_NEWLINE = 7'h0A;
  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_ONE     = 7'h31;
  localparam logic [6:0] CH_NINE    = 7'h39;
  localparam logic [6:0] CH_UPPER_A = 7'h41;
  localparam logic [6:0] CH_UPPER_F = 7'h46;

  typedef struct packed {
    logic [15:0] segment_base;
    logic        start_enable;
    logic [15:0] start_segment;
    logic [15:0] start_offset;
  } cfg_t;

  // One classified request: buffer write plus the records it emits
  typedef struct packed {
    logic              ext_seg;
    logic              start_seg;
    logic              data_rec;
    logic              eof_rec;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [7:0]        wr_byte;
    logic [FILL_W-1:0] data_len;
    logic [15:0]       data_ofs;
  } cmd_t;

  function automatic logic [6:0] hex_char(input logic [3:0] v);
    logic [6:0] r;
    if (v < 4'd10) begin
      r = CH_ZERO + {3'b000, v};
    end else begin
      r = CH_UPPER_A + {3'b000, v} - 7'd10;
    end
    return r;
  endfunction

endpackage

### rtl/ihex_if.sv
// Valid/ready channel interfaces for image bytes in and HEX characters out.
`timescale 1ns / 1ps
interface ihex_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] byte_value;
  modport source(output valid, operation, byte_value, input ready);
  modport sink(input valid, operation, byte_value, output ready);
endinterface

interface ihex_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       run_last;
  modport source(output valid, character, run_last, input ready);
  modport sink(input valid, character, run_last, output ready);
endinterface

### rtl/ihex_front.sv
// Front end: accepts image requests, tracks record fill and offset, issues commands.
`timescale 1ns / 1ps
module ihex_front (
  input  logic          clk,
  input  logic          rst,
  ihex_in_if.sink       image,
  input  logic          start_enable,
  output ihex_pkg::cmd_t push_cmd,
  output logic          push_valid,
  input  logic          push_ready
);
  import ihex_pkg::*;

  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [FILL_W-1:0] fill_inc;
  logic [15:0]       load_offset;
  logic [15:0]       load_offset_next;
  logic              header_sent;
  logic              header_sent_next;
  logic              accept;

  assign image.ready = push_ready;
  assign push_valid  = image.valid && (image.operation != OP_UNUSED);
  assign accept      = push_valid && push_ready;
  assign fill_inc    = fill + FILL_W'(1);

  // Classify the request and compute the next record state
  always_comb begin
    push_cmd           = '0;
    push_cmd.ext_seg   = !header_sent;
    push_cmd.start_seg = !header_sent && start_enable;
    push_cmd.wr_byte   = image.byte_value;
    push_cmd.wr_idx    = fill[IDX_W-1:0];
    push_cmd.data_ofs  = load_offset;
    fill_next          = fill;
    load_offset_next   = load_offset;
    header_sent_next   = header_sent;
    unique case (image.operation)
      OP_DATA, OP_END_SEG: begin
        push_cmd.wr_en   = 1'b1;
        header_sent_next = 1'b1;
        if ((fill_inc == FILL_W'(RECORD_BYTES)) || (image.operation == OP_END_SEG)) begin
          push_cmd.data_rec = 1'b1;
          push_cmd.data_len = fill_inc;
          fill_next         = '0;
          load_offset_next  = load_offset + 16'(fill_inc);
        end else begin
          fill_next = fill_inc;
        end
      end
      OP_END_IMAGE: begin
        push_cmd.data_rec = (fill != '0);
        push_cmd.data_len = fill;
        push_cmd.eof_rec  = 1'b1;
        fill_next         = '0;
        load_offset_next  = '0;
        header_sent_next  = 1'b0;
      end
      OP_UNUSED: begin
      end
    endcase
  end

  // Advance record state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      load_offset <= '0;
      header_sent <= 1'b0;
    end else if (accept) begin
      fill        <= fill_next;
      load_offset <= load_offset_next;
      header_sent <= header_sent_next;
    end
  end

endmodule

### rtl/ihex_queue.sv
// Short command queue between the front end and the character back end.
`timescale 1ns / 1ps
module ihex_queue (
  input  logic           clk,
  input  logic           rst,
  input  ihex_pkg::cmd_t push_cmd,
  input  logic           push_valid,
  output logic           push_ready,
  output ihex_pkg::cmd_t pop_cmd,
  output logic           pop_valid,
  input  logic           pop_ready
);
  import ihex_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/ihex_back.sv
// Back end: holds the record buffer and emits record characters one per cycle while hex.ready is high.
`timescale 1ns / 1ps
module ihex_back (
  input  logic           clk,
  input  logic           rst,
  input  ihex_pkg::cfg_t cfg,
  input  ihex_pkg::cmd_t pop_cmd,
  input  logic           pop_valid,
  output logic           pop_ready,
  ihex_out_if.source     hex
);
  import ihex_pkg::*;

  localparam logic [1:0] PH_COLON = 2'd0;
  localparam logic [1:0] PH_HI    = 2'd1;
  localparam logic [1:0] PH_LO    = 2'd2;
  localparam logic [1:0] PH_NL    = 2'd3;

  logic [7:0]        buffer [RECORD_BYTES];
  logic              busy;
  logic [3:0]        pend;
  logic [3:0]        cur_rec;
  logic [3:0]        rest;
  logic [1:0]        phase;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  data_pos;
  logic [7:0]        sum;
  logic [FILL_W-1:0] data_len;
  logic [15:0]       data_ofs;
  logic [7:0]        rec_len;
  logic [7:0]        rec_type;
  logic [15:0]       rec_ofs;
  logic [7:0]        payload;
  logic [7:0]        cur_byte;
  logic              is_cksum;
  logic [6:0]        cur_char;
  logic              cur_last;
  logic              emit;
  logic              out_valid;
  logic [6:0]        out_char;
  logic              out_last;

  assign pop_ready     = !busy;
  assign hex.valid     = out_valid;
  assign hex.character = out_char;
  assign hex.run_last  = out_last;
  assign emit          = busy && (!out_valid || hex.ready);

  // Pick the lowest pending record: header, start, data, end of file
  assign cur_rec  = pend & (~pend + 4'd1);
  assign rest     = pend & ~cur_rec;
  assign data_pos = pos - POS_W'(4);

  always_comb begin
    rec_len  = EOF_LEN;
    rec_type = REC_EOF;
    rec_ofs  = '0;
    payload  = buffer[data_pos[IDX_W-1:0]];
    priority if (cur_rec[0]) begin
      rec_len  = EXT_SEG_LEN;
      rec_type = REC_EXT_SEG;
      payload  = (data_pos == '0) ? cfg.segment_base[15:8] : cfg.segment_base[7:0];
    end else if (cur_rec[1]) begin
      rec_len  = START_SEG_LEN;
      rec_type = REC_START_SEG;
      unique case (data_pos[1:0])
        2'd0: payload = cfg.start_segment[15:8];
        2'd1: payload = cfg.start_segment[7:0];
        2'd2: payload = cfg.start_offset[15:8];
        2'd3: payload = cfg.start_offset[7:0];
      endcase
    end else if (cur_rec[2]) begin
      rec_len  = 8'(data_len);
      rec_type = REC_DATA;
      rec_ofs  = data_ofs;
    end else begin
      rec_len  = EOF_LEN;
      rec_type = REC_EOF;
    end
  end

  // Select the byte at the current position of the record
  assign is_cksum = (({1'b0, rec_len} + 9'd4) == 9'(pos));

  always_comb begin
    priority if (pos == POS_W'(0)) begin
      cur_byte = rec_len;
    end else if (pos == POS_W'(1)) begin
      cur_byte = rec_ofs[15:8];
    end else if (pos == POS_W'(2)) begin
      cur_byte = rec_ofs[7:0];
    end else if (pos == POS_W'(3)) begin
      cur_byte = rec_type;
    end else if (is_cksum) begin
      cur_byte = 8'd0 - sum;
    end else begin
      cur_byte = payload;
    end
  end

  always_comb begin
    unique case (phase)
      PH_COLON: cur_char = CH_COLON;
      PH_HI:    cur_char = hex_char(cur_byte[7:4]);
      PH_LO:    cur_char = hex_char(cur_byte[3:0]);
      PH_NL:    cur_char = CH_NEWLINE;
    endcase
  end

  assign cur_last = (phase == PH_NL) && (rest == '0);

  // Write buffered bytes as commands are taken
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready && pop_cmd.wr_en) begin
      buffer[pop_cmd.wr_idx] <= pop_cmd.wr_byte;
    end
  end

  // Load record parameters of a new command
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      data_len <= pop_cmd.data_len;
      data_ofs <= pop_cmd.data_ofs;
    end
  end

  // Sequence records and characters
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      pend  <= '0;
      phase <= PH_COLON;
      pos   <= '0;
      sum   <= '0;
    end else if (pop_valid && pop_ready) begin
      pend  <= {pop_cmd.eof_rec, pop_cmd.data_rec, pop_cmd.start_seg, pop_cmd.ext_seg};
      busy  <= pop_cmd.eof_rec || pop_cmd.data_rec || pop_cmd.start_seg || pop_cmd.ext_seg;
      phase <= PH_COLON;
    end else if (emit) begin
      unique case (phase)
        PH_COLON: begin
          phase <= PH_HI;
          pos   <= '0;
          sum   <= '0;
        end
        PH_HI: begin
          phase <= PH_LO;
        end
        PH_LO: begin
          sum <= sum + cur_byte;
          if (is_cksum) begin
            phase <= PH_NL;
          end else begin
            phase <= PH_HI;
            pos   <= pos + POS_W'(1);
          end
        end
        PH_NL: begin
          pend  <= rest;
          phase <= PH_COLON;
          if (rest == '0) begin
            busy <= 1'b0;
          end
        end
      endcase
    end
  end

  // Hold the output character until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (hex.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= cur_char;
      out_last <= cur_last;
    end
  end

endmodule

### rtl/intel_hex_record_encoder_unit.sv
// Top level of the Intel HEX record encoder: register port, front end, queue, back end.
//
// Usage:
//   image: valid/ready channel of requests (operation, byte_value). Operation 0 is a
//     data byte, 1 a data byte that closes the segment, 2 the end of the image; 3 is
//     taken and dropped. The first request of an image also emits the extended
//     segment address record and, when start_enable is set, the start address record.
//   hex: valid/ready channel of ASCII characters; run_last marks the final character
//     caused by one request. Requests that only buffer a byte produce nothing.
//   APB port: segment_base at 0x0, start_enable at 0x4, start_segment at 0x8,
//     start_offset at 0xC. Write only while the block is idle.
// Throughput: one character per cycle out of the back end's output register while hex.ready
//   is high; the back end takes the next request from the queue only once it is idle. A full
//   16-byte record costs 44 characters.
// Reset clears registers, record state and queue; the next request starts an image.
// A stalled hex channel holds its character; the two-entry queue keeps taking
//   requests until it fills, then image.ready drops.
`timescale 1ns / 1ps
module intel_hex_record_encoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ihex_pkg::PADDR_W-1:0]  paddr,
  input  logic [ihex_pkg::PDATA_W-1:0]  pwdata,
  output logic [ihex_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  ihex_in_if.sink                       image,
  ihex_out_if.source                    hex
);
  import ihex_pkg::*;

  cfg_t       cfg;
  cmd_t       push_cmd;
  cmd_t       pop_cmd;
  logic       push_valid;
  logic       push_ready;
  logic       pop_valid;
  logic       pop_ready;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_SEGMENT_BASE:  cfg.segment_base  <= pwdata[15:0];
        REG_START_ENABLE:  cfg.start_enable  <= pwdata[0];
        REG_START_SEGMENT: cfg.start_segment <= pwdata[15:0];
        REG_START_OFFSET:  cfg.start_offset  <= pwdata[15:0];
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_SEGMENT_BASE:  prdata = PDATA_W'(cfg.segment_base);
      REG_START_ENABLE:  prdata = PDATA_W'(cfg.start_enable);
      REG_START_SEGMENT: prdata = PDATA_W'(cfg.start_segment);
      REG_START_OFFSET:  prdata = PDATA_W'(cfg.start_offset);
    endcase
  end

  ihex_front u_front (
    .clk          (clk),
    .rst          (rst),
    .image        (image),
    .start_enable (cfg.start_enable),
    .push_cmd     (push_cmd),
    .push_valid   (push_valid),
    .push_ready   (push_ready)
  );

  ihex_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  ihex_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_cmd   (pop_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .hex       (hex)
  );

endmodule

### rtl/ihex_checker.sv
// Port-level checks of the Intel HEX record encoder, bound to the top level.
`timescale 1ns / 1ps
module ihex_checker (
  input logic       clk,
  input logic       rst,
  input logic       hex_valid,
  input logic       hex_ready,
  input logic [6:0] hex_character,
  input logic       hex_run_last
);
  import ihex_pkg::*;

  // Hold a stalled character
  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    hex_valid && !hex_ready |=> hex_valid)
    else $error("hex valid dropped while stalled");

  a_char_held: assert property (@(posedge clk) disable iff (rst)
    hex_valid && !hex_ready |=> $stable(hex_character) && $stable(hex_run_last))
    else $error("hex character changed while stalled");

  // Every request's output ends on a newline
  a_last_is_newline: assert property (@(posedge clk) disable iff (rst)
    hex_valid && hex_run_last |-> hex_character == CH_NEWLINE)
    else $error("last character of a request is not a newline");

  // Only record characters leave the block
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    hex_valid |-> (hex_character >= CH_ZERO && hex_character <= CH_NINE) ||
                  (hex_character >= CH_UPPER_A && hex_character <= CH_UPPER_F) ||
                  hex_character == CH_COLON || hex_character == CH_NEWLINE)
    else $error("character outside the record alphabet");

  // A record length never exceeds 0x1F, so its high digit follows the colon
  a_len_digit: assert property (@(posedge clk) disable iff (rst)
    hex_valid && hex_ready && hex_character == CH_COLON |=>
      !hex_valid || hex_character == CH_ZERO || hex_character == CH_ONE)
    else $error("bad length digit after record mark");

endmodule

bind intel_hex_record_encoder_unit ihex_checker u_ihex_checker (
  .clk           (clk),
  .rst           (rst),
  .hex_valid     (hex.valid),
  .hex_ready     (hex.ready),
  .hex_character (hex.character),
  .hex_run_last  (hex.run_last)
);

### dv/ihex_stream_checker.sv
// Checker of the Intel HEX record encoder: predicts characters per request and compares them.
`timescale 1ns / 1ps
module ihex_stream_checker
  import ihex_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  input  logic                 pready,
  ihex_in_if                   image,
  ihex_out_if                  hex,
  output int                   fail_count,
  output int                   chars_pending
);

  localparam int MAX_CHARS = 54;

  typedef struct packed {
    logic [6:0] character;
    logic       run_last;
  } hex_char_t;

  // Expected characters, oldest first
  hex_char_t hex_chars_due[$];

  // Register copies
  logic [15:0] seg_base;
  logic        start_en;
  logic [15:0] start_seg;
  logic [15:0] start_ofs;

  // Encoder state copies
  logic [127:0] open_bytes;
  int           fill;
  logic [15:0]  load_ofs;
  logic         hdr_sent;

  int         step_chars;
  logic [7:0] csum;
  int         err_total = 0;

  function automatic logic [6:0] nibble_char(input logic [3:0] v);
    logic [6:0] c;
    if (v < 4'd10) begin
      c = CH_ZERO + {3'b000, v};
    end else begin
      c = CH_UPPER_A + ({3'b000, v} - 7'd10);
    end
    return c;
  endfunction

  // Append one character, dropping any beyond the per-request bound
  function automatic void push_char(input logic [6:0] c);
    hex_char_t e;
    if (step_chars < MAX_CHARS) begin
      e.character = c;
      e.run_last  = 1'b0;
      hex_chars_due.push_back(e);
      step_chars++;
    end
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    csum = csum + b;
    push_char(nibble_char(b[7:4]));
    push_char(nibble_char(b[3:0]));
  endfunction

  // Byte i of the record body sits at body[8*i +: 8]
  function automatic void push_record(input int len, input logic [15:0] ofs,
                                      input logic [7:0] rtype, input logic [127:0] body);
    csum = 8'h00;
    push_char(CH_COLON);
    push_byte(len[7:0]);
    push_byte(ofs[15:8]);
    push_byte(ofs[7:0]);
    push_byte(rtype);
    for (int i = 0; i < len; i++) begin
      push_byte(body[8*i +: 8]);
    end
    push_byte(~csum + 8'd1);
    push_char(CH_NEWLINE);
  endfunction

  function automatic void flush_open_record();
    if (fill != 0) begin
      push_record(fill, load_ofs, REC_DATA, open_bytes);
      load_ofs = load_ofs + fill[15:0];
      fill     = 0;
    end
  endfunction

  // Work out the characters one accepted request causes
  function automatic void encode_request(input logic [1:0] op, input logic [7:0] b);
    hex_char_t tail;
    step_chars = 0;
    if (op != OP_UNUSED) begin
      if (!hdr_sent) begin
        push_record(int'(EXT_SEG_LEN), 16'h0000, REC_EXT_SEG,
                    {112'd0, seg_base[7:0], seg_base[15:8]});
        if (start_en) begin
          push_record(int'(START_SEG_LEN), 16'h0000, REC_START_SEG,
                      {96'd0, start_ofs[7:0], start_ofs[15:8], start_seg[7:0], start_seg[15:8]});
        end
        hdr_sent = 1'b1;
      end
      if (op == OP_END_IMAGE) begin
        flush_open_record();
        push_record(int'(EOF_LEN), 16'h0000, REC_EOF, open_bytes);
        fill     = 0;
        load_ofs = 16'h0000;
        hdr_sent = 1'b0;
      end else begin
        if (fill < RECORD_BYTES) begin
          open_bytes[8*fill +: 8] = b;
          fill++;
        end
        if (fill >= RECORD_BYTES || op == OP_END_SEG) begin
          flush_open_record();
        end
      end
      // Mark the final character of this request
      if (step_chars > 0) begin
        tail          = hex_chars_due.pop_back();
        tail.run_last = 1'b1;
        hex_chars_due.push_back(tail);
      end
    end
  endfunction

  // Snoop register writes, predict on requests, compare on characters
  always @(posedge clk) begin
    hex_char_t want;
    if (rst) begin
      seg_base   = 16'h0000;
      start_en   = 1'b0;
      start_seg  = 16'h0000;
      start_ofs  = 16'h0000;
      open_bytes = '0;
      fill       = 0;
      load_ofs   = 16'h0000;
      hdr_sent   = 1'b0;
      hex_chars_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SEGMENT_BASE:  seg_base  = pwdata[15:0];
          REG_START_ENABLE:  start_en  = pwdata[0];
          REG_START_SEGMENT: start_seg = pwdata[15:0];
          REG_START_OFFSET:  start_ofs = pwdata[15:0];
          default: ;
        endcase
      end
      if (image.valid && image.ready) begin
        encode_request(image.operation, image.byte_value);
      end
      if (hex.valid && hex.ready) begin
        if (hex_chars_due.size() == 0) begin
          $error("character: expected none, got %h", hex.character);
          err_total++;
        end else begin
          want = hex_chars_due.pop_front();
          if (hex.character !== want.character) begin
            $error("character: expected %h, got %h", want.character, hex.character);
            err_total++;
          end
          if (hex.run_last !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, hex.run_last);
            err_total++;
          end
        end
      end
    end
    fail_count    <= err_total;
    chars_pending <= hex_chars_due.size();
  end

endmodule

### dv/tb_intel_hex_record_encoder_unit.sv
// Testbench top of the Intel HEX record encoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_intel_hex_record_encoder_unit;
  import ihex_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE      = 6;
  localparam int PHASE_ITEMS = 55;

  logic               clk;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               hex_take = 1'b0;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int items_sent = 0;
  int idle_run = 0;
  int fail_count;
  int chars_pending;

  ihex_in_if  image_ch ();
  ihex_out_if hex_ch ();

  assign hex_ch.ready = hex_take;

  intel_hex_record_encoder_unit dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .image   (image_ch),
    .hex     (hex_ch)
  );

  ihex_stream_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .image         (image_ch),
    .hex           (hex_ch),
    .fail_count    (fail_count),
    .chars_pending (chars_pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Stall the character channel at random
  always @(posedge clk) begin
    hex_take <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((image_ch.valid && image_ch.ready) || (hex_ch.valid && hex_ch.ready) ||
          (psel && penable && pready)) begin
        idle_run <= 0;
      end else begin
        idle_run <= idle_run + 1;
      end
      if (idle_run >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Drive one request, with random idle cycles ahead of it
  task automatic send_request(input logic [1:0] op, input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      image_ch.valid <= 1'b0;
      @(posedge clk);
    end
    image_ch.valid      <= 1'b1;
    image_ch.operation  <= op;
    image_ch.byte_value <= b;
    do @(posedge clk); while (!image_ch.ready);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Drop valid, wait for every expected character, then let the block settle
  task automatic drain();
    image_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write one register; random bits above its width must be ignored
  task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
    logic [31:0] word;
    word = $urandom();
    if (idx == REG_START_ENABLE) begin
      word[0] = val[0];
    end else begin
      word[15:0] = val;
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_word();
    logic [15:0] w;
    case ($urandom_range(3))
      0:       w = 16'h0000;
      1:       w = 16'hFFFF;
      default: w = 16'($urandom);
    endcase
    return w;
  endfunction

  task automatic write_config(input logic [15:0] base, input logic en,
                              input logic [15:0] cs, input logic [15:0] ip);
    reg_write(REG_SEGMENT_BASE, base);
    reg_write(REG_START_ENABLE, {15'd0, en});
    reg_write(REG_START_SEGMENT, cs);
    reg_write(REG_START_OFFSET, ip);
  endtask

  // One image: data bytes, some ending a segment, optional noise, then end of image
  task automatic send_image(input int n_bytes, input int seg_odds, input bit noisy);
    for (int i = 0; i < n_bytes; i++) begin
      if (noisy && $urandom_range(11) == 0) begin
        send_request(OP_UNUSED, 8'($urandom));
      end
      if ($urandom_range(seg_odds - 1) == 0) begin
        send_request(OP_END_SEG, 8'($urandom));
      end else begin
        send_request(OP_DATA, 8'($urandom));
      end
    end
    send_request(OP_END_IMAGE, 8'($urandom));
  endtask

  initial begin
    int target;
    image_ch.valid      = 1'b0;
    image_ch.operation  = OP_DATA;
    image_ch.byte_value = 8'h00;
    target = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part
    src_idle_pct  = 25;
    snk_stall_pct = 79;
    write_config(16'hFFFF, 1'b1, 16'h0000, 16'hFFFF);
    // unused code before any image starts: no header
    send_request(OP_UNUSED, 8'hFF);
    // empty image
    send_request(OP_END_IMAGE, 8'h00);
    // short segment with extreme bytes
    send_request(OP_DATA, 8'h00);
    send_request(OP_DATA, 8'hFF);
    send_request(OP_END_SEG, 8'h5A);
    // full record
    for (int i = 0; i < RECORD_BYTES; i++) begin
      send_request(OP_DATA, 8'(i * 17));
    end
    send_request(OP_UNUSED, 8'h00);
    // end of image flushes a partial record
    send_request(OP_DATA, 8'h81);
    send_request(OP_END_IMAGE, 8'h3C);

    // Random part in three idling phases
    for (int p = 0; p < 3; p++) begin
      drain();
      case (p)
        0: begin
          src_idle_pct  = 25;
          snk_stall_pct = 79;
          write_config(16'h0000, 1'b0, 16'hFFFF, 16'h0000);
        end
        1: begin
          src_idle_pct  = 79;
          snk_stall_pct = 25;
          write_config(pick_word(), 1'b1, pick_word(), pick_word());
        end
        default: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
          write_config(pick_word(), 1'($urandom), pick_word(), pick_word());
        end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(2) == 0) begin
          drain();
          write_config(pick_word(), 1'($urandom), pick_word(), pick_word());
        end
        send_image($urandom_range(40), 8, 1'b1);
      end
    end

    drain();
    if (fail_count == 0 && chars_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
